/* rtl/core/sca_pkg.sv */
// Shared types, constants and the set-1 scan code decode table.
package sca_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned OUT_DATA_W = 8;

  // Item kinds carried on the input tuser bit.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NONE = '0;

  typedef struct packed {
    logic push;
    logic pop;
  } sca_fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sca_fifo_stat_t;

  // US QWERTY set-1 make codes; releases (bit 7) and unknown codes give CHAR_NONE.
  function automatic logic [CHAR_W-1:0] sca_decode_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    if (!code[CODE_W-1]) begin
      case (code[CODE_W-2:0])
        7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
        7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
        7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h3D;
        7'h0E: ch = 7'h08;
        7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
        7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
        7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
        7'h1C: ch = 7'h0A;
        7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73; 7'h20: ch = 7'h64; 7'h21: ch = 7'h66;
        7'h22: ch = 7'h67; 7'h23: ch = 7'h68; 7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B;
        7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B; 7'h28: ch = 7'h27; 7'h29: ch = 7'h60;
        7'h2B: ch = 7'h5C; 7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63;
        7'h2F: ch = 7'h76; 7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D;
        7'h33: ch = 7'h2C; 7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F;
        7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
        7'h47: ch = 7'h37; 7'h48: ch = 7'h38; 7'h49: ch = 7'h39; 7'h4A: ch = 7'h2D;
        7'h4B: ch = 7'h34; 7'h4C: ch = 7'h35; 7'h4D: ch = 7'h36; 7'h4E: ch = 7'h2B;
        7'h4F: ch = 7'h31; 7'h50: ch = 7'h32; 7'h51: ch = 7'h33; 7'h52: ch = 7'h30;
        7'h53: ch = 7'h2E;
        default: ch = CHAR_NONE;
      endcase
    end
    return ch;
  endfunction

endpackage

/* rtl/core/sca_decode.sv */
// Input register stage: decodes a scan code and holds the item until taken.
module sca_decode
  import sca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              op_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              ready_o,
  input  logic              take_i,
  output logic              valid_o,
  output logic              op_o,
  output logic [CHAR_W-1:0] char_o
);

  logic              valid_q, valid_d;
  logic              op_q;
  logic [CHAR_W-1:0] char_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (ready_o && valid_i) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_q   <= op_i;
      char_q <= sca_decode_char(code_i);
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign char_o  = char_q;

endmodule

/* rtl/core/sca_fifo.sv */
// Circular character buffer with registered read data.
module sca_fifo
  import sca_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sca_fifo_req_t     req_i,
  input  logic [CHAR_W-1:0] wr_char_i,
  output sca_fifo_stat_t    stat_o,
  output logic [CHAR_W-1:0] rd_char_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [CHAR_W-1:0] store_q [DEPTH];
  logic [CHAR_W-1:0] rd_char_q;
  logic [AW-1:0]     wr_idx_q, wr_idx_d, wr_next;
  logic [AW-1:0]     rd_idx_q, rd_idx_d, rd_next;

  assign wr_next = (wr_idx_q == LAST) ? '0 : wr_idx_q + 1'b1;
  assign rd_next = (rd_idx_q == LAST) ? '0 : rd_idx_q + 1'b1;

  assign stat_o.empty = (wr_idx_q == rd_idx_q);
  assign stat_o.full  = (wr_next == rd_idx_q);

  // Caller only pushes when not full and pops when not empty.
  assign wr_idx_d = req_i.push ? wr_next : wr_idx_q;
  assign rd_idx_d = req_i.pop  ? rd_next : rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      store_q[wr_idx_q] <= wr_char_i;
    end
  end

  // Read data holds between pops, so it doubles as the result payload.
  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rd_char_q <= store_q[rd_idx_q];
    end
  end

  assign rd_char_o = rd_char_q;

endmodule

/* rtl/core/scan_code_to_ascii_fifo.sv */
// A read passes the input register, then the result register and buffer read register together.
// Throughput: one transaction per cycle on the slave side while the master side drains.
// Scan code transactions give no result; a decoded character is buffered (DEPTH-1 max).
// Reset clears the input stage, result stage and both buffer pointers at once.
// Buffer contents are not cleared; an entry is only read after it is written.
module scan_code_to_ascii_fifo
  import sca_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CODE_W-1:0]     s_axis_tdata,  // [7:0] key_code
  input  logic                  s_axis_tuser,  // [0] op (0 scan code, 1 read)
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [6:0] char_code, [7] zero pad
  output logic                  m_axis_tuser   // [0] empty_res
);

  logic              a_valid;
  logic              a_op;
  logic [CHAR_W-1:0] a_char;
  logic              a_take;
  logic              res_ready;

  sca_fifo_req_t     fifo_req;
  sca_fifo_stat_t    fifo_stat;
  logic [CHAR_W-1:0] rd_char;

  logic              res_valid_q, res_valid_d;
  logic              res_empty_q;

  // Input register stage with table decode in front of it.
  sca_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .code_i  (s_axis_tdata),
    .ready_o (s_axis_tready),
    .take_i  (a_take),
    .valid_o (a_valid),
    .op_o    (a_op),
    .char_o  (a_char)
  );

  // Result register is free when empty or being drained this cycle.
  assign res_ready = !res_valid_q || m_axis_tready;

  // Scan codes always retire; reads wait for room in the result register.
  assign a_take = a_valid && ((a_op == OP_SCAN) || res_ready);

  // Drop unknown codes, releases, and characters that arrive while the buffer is full.
  assign fifo_req.push = a_take && (a_op == OP_SCAN) && (a_char != CHAR_NONE)
                         && !fifo_stat.full;
  assign fifo_req.pop  = a_take && (a_op == OP_READ) && !fifo_stat.empty;

  sca_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (fifo_req),
    .wr_char_i (a_char),
    .stat_o    (fifo_stat),
    .rd_char_o (rd_char)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (m_axis_tready) begin
      res_valid_d = 1'b0;
    end
    if (a_take && (a_op == OP_READ)) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take && (a_op == OP_READ)) begin
      res_empty_q <= fifo_stat.empty;
    end
  end

  // Character comes from the buffer read register; an empty read shows zero.
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_empty_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}},
                          (res_empty_q ? CHAR_NONE : rd_char)};

endmodule

/* rtl/core/sca_checker.sv */
// Port-level checks for the scan code FIFO, bound to the top level.
module sca_checker
  import sca_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // Stalled result holds its transaction.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input only backs up when the result side is full and stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // Empty read carries a zero character.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty read with nonzero character");

  // Buffered characters are never zero and are 7-bit.
  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata != '0) && !m_axis_tdata[OUT_DATA_W-1])
    else $error("popped character out of range");

endmodule

bind scan_code_to_ascii_fifo sca_checker u_sca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
